// ----- design/i2cra_pkg.sv -----
`default_nettype none
package i2cra_pkg;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'd1;

  localparam logic [7:0] DELAY_TICKS_RST = 8'd10;
  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_WRITE,
    CMD_READ
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [6:0] dev_addr;
    logic [7:0] reg_offset;
    logic [7:0] wr_data;
    logic [7:0] read_count;
    logic       sda_in;
  } item_t;

endpackage
`default_nettype wire

// ----- design/i2c_master_register_access.sv -----
// channel   direction  handshake            word
// in_       input      in_valid / in_stall   op, addresses, data, count, sampled sda
// out_      output     out_valid / out_stall pin levels, busy, read byte, done, error
// cfg_      input      cfg_valid / cfg_ready register index and write data
//
// one tick is taken per clock unless out_stall holds the engine; a tick leaves
// the four-word input queue when popped, and its result is registered at that edge.
// out_stall holds the result register and then the engine; the queue absorbs
// up to four ticks before in_stall rises. cfg_ready is always high.
// rst_n is synchronous, active low: engine idle, lines released, queue empty,
// delay 10 ticks, acknowledge timeout 250 polls.
`default_nettype none
module i2c_master_register_access (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        in_op,
  input  wire logic [6:0]                        in_dev_addr,
  input  wire logic [7:0]                        in_reg_offset,
  input  wire logic [7:0]                        in_wr_data,
  input  wire logic [7:0]                        in_read_count,
  input  wire logic                              in_sda_in,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_scl_level,
  output logic                                   out_sda_level,
  output logic                                   out_busy_res,
  output logic [7:0]                             out_rd_byte,
  output logic                                   out_rd_valid,
  output logic                                   out_rd_last,
  output logic                                   out_done_res,
  output logic                                   out_nack_error,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [i2cra_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [7:0]                        cfg_data
);

  logic             item_valid;
  logic             item_pop;
  i2cra_pkg::item_t item;

  assign cfg_ready = 1'b1;

  i2cra_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_dev_addr   (in_dev_addr),
    .in_reg_offset (in_reg_offset),
    .in_wr_data    (in_wr_data),
    .in_read_count (in_read_count),
    .in_sda_in     (in_sda_in),
    .item_valid    (item_valid),
    .item          (item),
    .item_pop      (item_pop)
  );

  i2cra_engine u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_valid     (item_valid),
    .item           (item),
    .item_pop       (item_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_scl_level  (out_scl_level),
    .out_sda_level  (out_sda_level),
    .out_busy_res   (out_busy_res),
    .out_rd_byte    (out_rd_byte),
    .out_rd_valid   (out_rd_valid),
    .out_rd_last    (out_rd_last),
    .out_done_res   (out_done_res),
    .out_nack_error (out_nack_error)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done reported while still busy");

  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rd_last |-> out_rd_valid)
    else $error("last flag without a read byte");

  a_nack_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_nack_error |-> out_done_res)
    else $error("ack error outside done");

  a_rd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rd_valid |-> out_busy_res && !out_done_res)
    else $error("read byte outside a transaction");

endmodule
`default_nettype wire

// ----- design/i2cra_front.sv -----
`default_nettype none
module i2cra_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [1:0]      in_op,
  input  wire logic [6:0]      in_dev_addr,
  input  wire logic [7:0]      in_reg_offset,
  input  wire logic [7:0]      in_wr_data,
  input  wire logic [7:0]      in_read_count,
  input  wire logic            in_sda_in,
  output logic                 item_valid,
  output i2cra_pkg::item_t     item,
  input  wire logic            item_pop
);

  i2cra_pkg::item_t                   mem [i2cra_pkg::FIFO_DEPTH];
  logic [i2cra_pkg::FIFO_AW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [i2cra_pkg::FIFO_AW:0]        count_r, count_nxt;
  i2cra_pkg::item_t                   new_item;
  logic                               push;

  always_comb begin
    new_item.dev_addr   = in_dev_addr;
    new_item.reg_offset = in_reg_offset;
    new_item.wr_data    = in_wr_data;
    new_item.sda_in     = in_sda_in;
    // zero count means one byte
    new_item.read_count = (in_read_count == 8'd0) ? 8'd1 : in_read_count;
    unique case (in_op)
      i2cra_pkg::OP_WRITE: new_item.cmd = i2cra_pkg::CMD_WRITE;
      i2cra_pkg::OP_READ:  new_item.cmd = i2cra_pkg::CMD_READ;
      default:             new_item.cmd = i2cra_pkg::CMD_TICK;
    endcase
  end

  assign in_stall   = (count_r == (i2cra_pkg::FIFO_AW+1)'(i2cra_pkg::FIFO_DEPTH));
  assign push       = in_valid && !in_stall;
  assign item_valid = (count_r != '0);
  assign item       = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !item_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && item_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (item_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= new_item;
    end
  end

endmodule
`default_nettype wire

// ----- design/i2cra_engine.sv -----
`default_nettype none
module i2cra_engine (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  input  wire logic [i2cra_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [7:0]                        cfg_data,
  input  wire logic                              item_valid,
  input  wire i2cra_pkg::item_t                  item,
  output logic                                   item_pop,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_scl_level,
  output logic                                   out_sda_level,
  output logic                                   out_busy_res,
  output logic [7:0]                             out_rd_byte,
  output logic                                   out_rd_valid,
  output logic                                   out_rd_last,
  output logic                                   out_done_res,
  output logic                                   out_nack_error
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_START_PRE, PH_START_HI, PH_START_FALL, PH_START_CLK,
    PH_TX_LOW, PH_TX_HIGH, PH_ACK_LOW, PH_ACK_REL, PH_ACK_HIGH,
    PH_ACK_POLL, PH_ACK_END, PH_RX_LOW, PH_RX_HIGH, PH_MACK_LOW,
    PH_MACK_DATA, PH_MACK_HIGH, PH_MACK_END, PH_STOP_A, PH_STOP_B,
    PH_STOP_C, PH_STOP_D
  } phase_t;

  logic [7:0] delay_r, ack_to_r;

  phase_t     phase_r, phase_nxt;
  logic [3:0] bit_r, bit_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [8:0] wait_r, wait_nxt;
  logic [7:0] poll_r, poll_nxt;
  logic [7:0] left_r, left_nxt;
  logic [6:0] addr_r, addr_nxt;
  logic [7:0] offs_r, offs_nxt;
  logic [7:0] data_r, data_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] stage_r, stage_nxt;
  logic       err_r, err_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;

  logic       out_valid_r;
  logic       out_scl_r, out_sda_r, out_busy_r;
  logic [7:0] out_byte_r, rbyte;
  logic       out_rv_r, out_rl_r, out_done_r, out_nack_r;
  logic       rvalid, rlast, done, nack;

  logic [8:0] unit1, unit2;
  logic [3:0] bit_inc;
  logic       fire;

  assign unit1    = {1'b0, delay_r};
  assign unit2    = {delay_r, 1'b0};
  assign bit_inc  = bit_r + 4'd1;
  assign fire     = item_valid && (!out_valid_r || !out_stall);
  assign item_pop = fire;

  always_comb begin
    phase_nxt = phase_r; bit_nxt = bit_r; shift_nxt = shift_r; wait_nxt = wait_r;
    poll_nxt = poll_r; left_nxt = left_r; addr_nxt = addr_r; offs_nxt = offs_r;
    data_nxt = data_r; rd_nxt = rd_r; stage_nxt = stage_r; err_nxt = err_r;
    scl_nxt = scl_r; sda_nxt = sda_r;
    rbyte = 8'd0; rvalid = 1'b0; rlast = 1'b0; done = 1'b0; nack = 1'b0;

    if (phase_r == PH_IDLE) begin
      scl_nxt = 1'b1;
      sda_nxt = 1'b1;
      if (item.cmd != i2cra_pkg::CMD_TICK) begin
        addr_nxt  = item.dev_addr;
        offs_nxt  = item.reg_offset;
        data_nxt  = item.wr_data;
        rd_nxt    = (item.cmd == i2cra_pkg::CMD_READ);
        left_nxt  = item.read_count;
        stage_nxt = 2'd0;
        err_nxt   = 1'b0;
        phase_nxt = PH_START_PRE;
        wait_nxt  = unit2;
      end
    end else if (phase_r == PH_ACK_POLL) begin
      if (!item.sda_in) begin
        scl_nxt   = 1'b0;
        phase_nxt = PH_ACK_END;
        wait_nxt  = unit1;
      end else if (poll_r >= ack_to_r) begin
        err_nxt   = 1'b1;
        scl_nxt   = 1'b0;
        phase_nxt = PH_STOP_A;
        wait_nxt  = unit1;
      end else begin
        poll_nxt = poll_r + 8'd1;
      end
    end else if (wait_r > 9'd1) begin
      wait_nxt = wait_r - 9'd1;
    end else begin
      unique case (phase_r)
        PH_START_PRE: begin
          scl_nxt = 1'b1; sda_nxt = 1'b1; phase_nxt = PH_START_HI; wait_nxt = unit2;
        end
        PH_START_HI: begin
          sda_nxt = 1'b0; phase_nxt = PH_START_FALL; wait_nxt = unit2;
        end
        PH_START_FALL: begin
          scl_nxt = 1'b0; phase_nxt = PH_START_CLK; wait_nxt = unit2;
        end
        PH_START_CLK: begin
          shift_nxt = {addr_r, stage_r == 2'd2};
          bit_nxt   = 4'd0;
          scl_nxt   = 1'b0;
          sda_nxt   = addr_r[6];
          phase_nxt = PH_TX_LOW;
          wait_nxt  = unit1;
        end
        PH_TX_LOW: begin
          scl_nxt = 1'b1; phase_nxt = PH_TX_HIGH; wait_nxt = unit1;
        end
        PH_TX_HIGH: begin
          shift_nxt = {shift_r[6:0], 1'b0};
          bit_nxt   = bit_inc;
          scl_nxt   = 1'b0;
          wait_nxt  = unit1;
          if (bit_inc >= 4'd8) begin
            phase_nxt = PH_ACK_LOW;
          end else begin
            sda_nxt   = shift_r[6];
            phase_nxt = PH_TX_LOW;
          end
        end
        PH_ACK_LOW: begin
          sda_nxt = 1'b1; phase_nxt = PH_ACK_REL; wait_nxt = unit2;
        end
        PH_ACK_REL: begin
          scl_nxt = 1'b1; phase_nxt = PH_ACK_HIGH; wait_nxt = unit1;
        end
        PH_ACK_HIGH: begin
          poll_nxt = 8'd0; phase_nxt = PH_ACK_POLL; wait_nxt = 9'd0;
        end
        PH_ACK_END: begin
          if (stage_r == 2'd0) begin
            stage_nxt = 2'd1;
            shift_nxt = offs_r; bit_nxt = 4'd0; scl_nxt = 1'b0; sda_nxt = offs_r[7];
            phase_nxt = PH_TX_LOW; wait_nxt = unit1;
          end else if (stage_r == 2'd1) begin
            stage_nxt = 2'd2;
            if (rd_r) begin
              phase_nxt = PH_START_PRE; wait_nxt = unit2;
            end else begin
              shift_nxt = data_r; bit_nxt = 4'd0; scl_nxt = 1'b0; sda_nxt = data_r[7];
              phase_nxt = PH_TX_LOW; wait_nxt = unit1;
            end
          end else if (rd_r) begin
            shift_nxt = 8'd0; bit_nxt = 4'd0; scl_nxt = 1'b0; sda_nxt = 1'b1;
            phase_nxt = PH_RX_LOW; wait_nxt = unit1;
          end else begin
            scl_nxt = 1'b0; phase_nxt = PH_STOP_A; wait_nxt = unit1;
          end
        end
        PH_RX_LOW: begin
          scl_nxt = 1'b1; phase_nxt = PH_RX_HIGH; wait_nxt = unit1;
        end
        PH_RX_HIGH: begin
          shift_nxt = {shift_r[6:0], item.sda_in};
          bit_nxt   = bit_inc;
          scl_nxt   = 1'b0;
          wait_nxt  = unit1;
          if (bit_inc >= 4'd8) begin
            rbyte     = {shift_r[6:0], item.sda_in};
            rvalid    = 1'b1;
            rlast     = (left_r <= 8'd1);
            phase_nxt = PH_MACK_LOW;
          end else begin
            phase_nxt = PH_RX_LOW;
          end
        end
        PH_MACK_LOW: begin
          sda_nxt = (left_r <= 8'd1); phase_nxt = PH_MACK_DATA; wait_nxt = unit1;
        end
        PH_MACK_DATA: begin
          scl_nxt = 1'b1; phase_nxt = PH_MACK_HIGH; wait_nxt = unit1;
        end
        PH_MACK_HIGH: begin
          scl_nxt = 1'b0; phase_nxt = PH_MACK_END; wait_nxt = unit1;
        end
        PH_MACK_END: begin
          if (left_r <= 8'd1) begin
            left_nxt = 8'd0;
            scl_nxt = 1'b0; phase_nxt = PH_STOP_A; wait_nxt = unit1;
          end else begin
            left_nxt  = left_r - 8'd1;
            shift_nxt = 8'd0; bit_nxt = 4'd0; scl_nxt = 1'b0; sda_nxt = 1'b1;
            phase_nxt = PH_RX_LOW; wait_nxt = unit1;
          end
        end
        PH_STOP_A: begin
          sda_nxt = 1'b0; phase_nxt = PH_STOP_B; wait_nxt = unit1;
        end
        PH_STOP_B: begin
          scl_nxt = 1'b1; phase_nxt = PH_STOP_C; wait_nxt = unit2;
        end
        PH_STOP_C: begin
          sda_nxt = 1'b1; phase_nxt = PH_STOP_D; wait_nxt = unit2;
        end
        PH_STOP_D: begin
          done = 1'b1; nack = err_r; phase_nxt = PH_IDLE; wait_nxt = 9'd0;
        end
        default: begin
          phase_nxt = PH_IDLE; wait_nxt = 9'd0; scl_nxt = 1'b1; sda_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r  <= i2cra_pkg::DELAY_TICKS_RST;
      ack_to_r <= i2cra_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == i2cra_pkg::CFG_DELAY_TICKS) begin
        delay_r <= cfg_data;
      end
      if (cfg_index == i2cra_pkg::CFG_ACK_TIMEOUT) begin
        ack_to_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; bit_r <= '0; shift_r <= '0; wait_r <= '0; poll_r <= '0;
      left_r <= '0; addr_r <= '0; offs_r <= '0; data_r <= '0; rd_r <= 1'b0;
      stage_r <= '0; err_r <= 1'b0; scl_r <= 1'b1; sda_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        phase_r <= phase_nxt; bit_r <= bit_nxt; shift_r <= shift_nxt;
        wait_r <= wait_nxt; poll_r <= poll_nxt; left_r <= left_nxt;
        addr_r <= addr_nxt; offs_r <= offs_nxt; data_r <= data_nxt;
        rd_r <= rd_nxt; stage_r <= stage_nxt; err_r <= err_nxt;
        scl_r <= scl_nxt; sda_r <= sda_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_scl_r  <= scl_nxt;
      out_sda_r  <= sda_nxt;
      out_busy_r <= (phase_nxt != PH_IDLE);
      out_byte_r <= rbyte;
      out_rv_r   <= rvalid;
      out_rl_r   <= rlast;
      out_done_r <= done;
      out_nack_r <= nack;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_scl_level  = out_scl_r;
  assign out_sda_level  = out_sda_r;
  assign out_busy_res   = out_busy_r;
  assign out_rd_byte    = out_byte_r;
  assign out_rd_valid   = out_rv_r;
  assign out_rd_last    = out_rl_r;
  assign out_done_res   = out_done_r;
  assign out_nack_error = out_nack_r;

endmodule
`default_nettype wire
